FILE: rtl/fifo_replacement_assoc_cache_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the associative cache unit
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FIFO_REPLACEMENT_ASSOC_CACHE_UNIT_MACROS_SVH
`define FIFO_REPLACEMENT_ASSOC_CACHE_UNIT_MACROS_SVH

// Same-cycle implication.
`define FARC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FARC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/farc_pkg.sv
// ----------------------------------------------------------------------------
// farc_pkg
// Shared types and constants of the associative cache unit.
// ----------------------------------------------------------------------------
package farc_pkg;

  localparam int KEY_W         = 10;
  localparam int CFG_W         = 5;
  localparam int DEPTH_DEF     = 16;
  localparam int PAYLOAD_W_DEF = 32;

  localparam logic [CFG_W-1:0] ENTRIES_RST = 5'd16;

  typedef enum logic {
    FUNC_LOOKUP   = 1'b0,
    FUNC_REGISTER = 1'b1
  } farc_func_e;

  // Request from the control logic to the tag array.
  typedef struct packed {
    logic             valid;
    farc_func_e       func;
    logic [KEY_W-1:0] key;
  } farc_req_t;

endpackage

FILE: rtl/farc_ram.sv
// ----------------------------------------------------------------------------
// farc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module farc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/farc_tags.sv
// ----------------------------------------------------------------------------
// farc_tags
// Key and valid store with parallel compare, lowest-index priority pick and
// the round-robin insert pointer.
// ----------------------------------------------------------------------------
module farc_tags #(
  parameter int DEPTH = farc_pkg::DEPTH_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  farc_pkg::farc_req_t                        req_i,
  input  logic [farc_pkg::CFG_W-1:0]                 slots_i,
  output logic                                       hit_o,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] hit_slot_o,
  output logic                                       ins_en_o,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ins_slot_o
);
  import farc_pkg::*;

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam int CmpW = (CntW > CFG_W) ? CntW : CFG_W;

  logic [KEY_W-1:0] keys_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [IdxW-1:0]  ptr_q, ptr_d;

  logic [CmpW-1:0]  cfg_ext, n_act;
  logic [DEPTH-1:0] match;
  logic [IdxW-1:0]  cur_slot, hit_slot;
  logic [CmpW-1:0]  nxt_ext;

  // Clamp the slot count into 1..DEPTH.
  assign cfg_ext = CmpW'(slots_i);
  assign n_act   = (cfg_ext == '0) ? CmpW'(1) :
                   (cfg_ext > CmpW'(DEPTH)) ? CmpW'(DEPTH) : cfg_ext;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
    assign match[i] = valid_q[i] && (keys_q[i] == req_i.key) && (CmpW'(i) < n_act);
  end

  always_comb begin
    hit_slot = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_slot = IdxW'(i);
      end
    end
  end

  // Pointer past the active range restarts at slot 0.
  assign cur_slot = (CmpW'(ptr_q) >= n_act) ? '0 : ptr_q;
  assign nxt_ext  = CmpW'(cur_slot) + CmpW'(1);
  assign ptr_d    = (nxt_ext >= n_act) ? '0 : IdxW'(nxt_ext);

  assign hit_o      = |match;
  assign hit_slot_o = hit_slot;
  assign ins_en_o   = req_i.valid && (req_i.func == FUNC_REGISTER) && !(|match);
  assign ins_slot_o = cur_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
    end else if (ins_en_o) begin
      valid_q[cur_slot] <= 1'b1;
      ptr_q             <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_en_o) begin
      keys_q[cur_slot] <= req_i.key;
    end
  end

endmodule

FILE: rtl/fifo_replacement_assoc_cache_unit.sv
// ----------------------------------------------------------------------------
// fifo_replacement_assoc_cache_unit
// Fully associative cache with first-in first-out replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser carries the operation (0 lookup, 1 register), tdata
//   carries the key in the low 10 bits and the payload above it. A lookup
//   returns a hit flag and the stored payload of the lowest matching slot.
//   A register word stores key and payload in the slot under the insert
//   pointer when the key is absent; the hit flag tells if it was present.
//   Output stream: tuser is the hit flag, tdata the payload (zero on a miss
//   and on every register word).
//   An accepted word's hit flag and payload read are registered; ready
//   stays low until the response state loads the output register. The
//   key compare runs against flops in the accept cycle.
//   A word may be accepted while the previous result still waits; the
//   response then holds until the output register drains.
//   Configuration: cfg_wdata_i sets the active slot count (0 acts as 1,
//   above DEPTH acts as DEPTH); write only while the unit is idle.
//   Reset clears all valid bits and the insert pointer; the slot count
//   returns to 16. No clearing pass is needed; ready comes up at once.
// ----------------------------------------------------------------------------
`include "fifo_replacement_assoc_cache_unit_macros.svh"

module fifo_replacement_assoc_cache_unit #(
  parameter int DEPTH         = farc_pkg::DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = farc_pkg::PAYLOAD_W_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // configuration: active slot count
  input  logic                         cfg_we_i,
  input  logic [farc_pkg::CFG_W-1:0]   cfg_wdata_i,
  // input stream
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // tdata: [9:0] key, [PAYLOAD_WIDTH+9:10] payload, zero pad above
  input  logic [((farc_pkg::KEY_W + PAYLOAD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  // tuser: [0] func
  input  logic s_axis_tuser_i,
  // output stream
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // tdata: [PAYLOAD_WIDTH-1:0] data_out, zero pad above
  output logic [((PAYLOAD_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata_o,
  // tuser: [0] hit
  output logic m_axis_tuser_o
);
  import farc_pkg::*;

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OutW = ((PAYLOAD_WIDTH + 7) / 8) * 8;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_e;

  state_e                   state_q;
  logic [CFG_W-1:0]         slots_q;
  farc_func_e               func_q;
  logic                     hit_q;
  logic                     m_valid_q;
  logic                     m_hit_q;
  logic [OutW-1:0]          m_data_q;

  farc_req_t                req;
  logic                     in_fire, out_free;
  logic                     hit, ins_en;
  logic [IdxW-1:0]          hit_slot, ins_slot;
  logic [PAYLOAD_WIDTH-1:0] rdata, in_payload;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  assign req.valid  = in_fire;
  assign req.func   = farc_func_e'(s_axis_tuser_i);
  assign req.key    = s_axis_tdata_i[KEY_W-1:0];
  assign in_payload = s_axis_tdata_i[KEY_W +: PAYLOAD_WIDTH];

  // Slot count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= ENTRIES_RST;
    end else if (cfg_we_i) begin
      slots_q <= cfg_wdata_i;
    end
  end

  // Compare the key against every active slot in the accept cycle.
  farc_tags #(
    .DEPTH (DEPTH)
  ) u_tags (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .slots_i    (slots_q),
    .hit_o      (hit),
    .hit_slot_o (hit_slot),
    .ins_en_o   (ins_en),
    .ins_slot_o (ins_slot)
  );

  // Payload store: write on insert, read the matching slot on lookup.
  farc_ram #(
    .WIDTH (PAYLOAD_WIDTH),
    .DEPTH (DEPTH)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ins_en),
    .waddr_i (ins_slot),
    .wdata_i (in_payload),
    .re_i    (in_fire && (req.func == FUNC_LOOKUP)),
    .raddr_i (hit_slot),
    .rdata_o (rdata)
  );

  // Sequencer and output register. The RAM read data holds while the
  // response waits, since no new read is issued until the next accept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      func_q    <= FUNC_LOOKUP;
      hit_q     <= 1'b0;
      m_valid_q <= 1'b0;
      m_hit_q   <= 1'b0;
      m_data_q  <= '0;
    end else begin
      // Drop the taken word unless a response loads in its place.
      if (m_axis_tready_i && (state_q != ST_RESP)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            func_q  <= req.func;
            hit_q   <= hit;
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_hit_q   <= hit_q;
            m_data_q  <= (hit_q && (func_q == FUNC_LOOKUP)) ? OutW'(rdata) : '0;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_hit_q;
  assign m_axis_tdata_o  = m_data_q;

  `FARC_ASSERT_NEXT(a_accept_blocks, in_fire, !s_axis_tready_o, "accept did not enter response")
  `FARC_ASSERT_IMPL(a_insert_on_register, ins_en, in_fire && (req.func == FUNC_REGISTER) && !hit, "insert without register miss")
  `FARC_ASSERT_NEXT(a_resp_delivers, (state_q == ST_RESP) && out_free, m_axis_tvalid_o && s_axis_tready_o, "response not loaded")

endmodule

FILE: tb/sv/tb_fifo_replacement_assoc_cache_unit.sv
// ----------------------------------------------------------------------------
// tb_fifo_replacement_assoc_cache_unit
// Self-checking bench for the associative cache with first-in first-out
// replacement. A directed table walks empty, extreme and eviction cases
// across slot-count changes. Random lookups and registers then run over a
// small key pool per phase, so that hits, duplicates and evictions are
// frequent. Each output word is checked against a fixed row expectation or
// a shadow copy of the cache that the bench updates on each accepted word.
// ----------------------------------------------------------------------------
module tb_fifo_replacement_assoc_cache_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import farc_pkg::*;

  localparam int DEPTH           = DEPTH_DEF;
  localparam int PAY_W           = PAYLOAD_W_DEF;
  localparam int IN_DATA_W       = ((KEY_W + PAY_W + 7) / 8) * 8;
  localparam int OUT_DATA_W      = ((PAY_W + 7) / 8) * 8;
  localparam int STALL_LIMIT     = 2000;
  localparam int NUM_PHASES      = 12;
  localparam int WORDS_PER_PHASE = 54;
  localparam int HOLDOFF_CYCLES  = 80;
  localparam int PRESSURE_PHASE  = 4;
  localparam int PRESSURE_WORDS  = 12;
  localparam int NUM_DIR_ROWS    = 26;
  localparam int PRINT_CAP       = 100;

  localparam logic [KEY_W-1:0] KEY_MAX = '1;
  localparam logic [PAY_W-1:0] PAY_MAX = '1;

  // One expected output word: hit flag and returned payload.
  typedef struct packed {
    logic             hit;
    logic [PAY_W-1:0] data;
  } cache_resp_t;

  // Directed rows: fixed expectation, shadow-cache expectation, or a
  // slot-count write.
  typedef enum logic [1:0] {
    ROW_FIXED,
    ROW_PREDICT,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    farc_func_e       func;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic             exp_hit;
    logic [PAY_W-1:0] exp_data;
    logic [CFG_W-1:0] slots;
  } stim_row_t;

  // --------------------------------------------------------------------------
  // DUT signals, inputs driven to known values from time zero
  // --------------------------------------------------------------------------
  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata_i     = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  // tdata: [9:0] key, [41:10] payload, zero pad above
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  // tuser: [0] func
  logic                  s_axis_tuser_i  = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // tdata: [31:0] data_out
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  // tuser: [0] hit
  logic                  m_axis_tuser_o;

  fifo_replacement_assoc_cache_unit #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAY_W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shadow cache: slot contents, fill pointer and raw slot-count register
  // --------------------------------------------------------------------------
  logic [KEY_W-1:0] slot_key     [DEPTH];
  logic [PAY_W-1:0] slot_payload [DEPTH];
  logic             slot_valid   [DEPTH] = '{default: 1'b0};
  int               fill_ptr       = 0;
  logic [CFG_W-1:0] slot_count_cfg = ENTRIES_RST;

  cache_resp_t pending_resps[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int holdoff_req    = 0;
  int holdoff_left   = 0;

  int mismatch_count = 0;
  int results_seen   = 0;
  int quiet_cycles   = 0;
  int n_words        = 0;
  int n_lookups      = 0;
  int n_registers    = 0;
  int n_hits         = 0;
  int n_dups         = 0;
  int cfg_writes     = 0;

  // Search the active slots lowest index first; on a register miss, fill the
  // slot under the pointer and advance it, wrapping at the active count.
  function automatic cache_resp_t cache_access(farc_func_e       func,
                                               logic [KEY_W-1:0] key,
                                               logic [PAY_W-1:0] payload);
    cache_resp_t resp;
    int          n;
    int          p;
    int          hit_slot;
    // A count of zero acts as one, anything above the depth as the depth.
    n = (slot_count_cfg == 0) ? 1 :
        (int'(slot_count_cfg) > DEPTH) ? DEPTH : int'(slot_count_cfg);
    hit_slot = -1;
    for (int i = 0; i < n; i++) begin
      if (hit_slot < 0 && slot_valid[i] && slot_key[i] == key) hit_slot = i;
    end
    resp.hit  = (hit_slot >= 0);
    resp.data = '0;
    if (func == FUNC_LOOKUP) begin
      if (hit_slot >= 0) resp.data = slot_payload[hit_slot];
    end else if (hit_slot < 0) begin
      // A pointer left beyond a shrunk count restarts at slot 0.
      p = (fill_ptr >= n) ? 0 : fill_ptr;
      slot_key[p]     = key;
      slot_payload[p] = payload;
      slot_valid[p]   = 1'b1;
      p++;
      fill_ptr = (p >= n) ? 0 : p;
    end
    return resp;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_CAP) $display("[%0t] ERROR: %s", $time, msg);
    mismatch_count++;
  endtask

  // Offer one word after random idle cycles, hold it until accepted, then
  // queue its expected result. Returns at the accepting edge.
  task automatic send_word(farc_func_e func, logic [KEY_W-1:0] key,
                           logic [PAY_W-1:0] payload, bit fixed,
                           cache_resp_t fixed_resp);
    cache_resp_t resp;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= func;
    s_axis_tdata_i  <= IN_DATA_W'({payload, key});
    do @(posedge clk_i); while (!s_axis_tready_o);
    resp = cache_access(func, key, payload);
    n_words++;
    if (func == FUNC_LOOKUP) begin
      n_lookups++;
      if (resp.hit) n_hits++;
    end else begin
      n_registers++;
      if (resp.hit) n_dups++;
    end
    pending_resps.push_back(fixed ? fixed_resp : resp);
  endtask

  // Drop valid and hold until every expected word has come back.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_resps.size() != 0) @(posedge clk_i);
  endtask

  // Write the slot count only with the unit idle; leave a short margin past
  // the last result for the output register to settle.
  task automatic write_slot_count(logic [CFG_W-1:0] value);
    drain_results();
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    slot_count_cfg  = value;
    cfg_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls per phase, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (holdoff_req != 0) begin
      holdoff_left = holdoff_req;
      holdoff_req  = 0;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Output check and watchdog: compare each accepted word field by field
  // with the oldest expectation; end the run if nothing moves for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cache_resp_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        results_seen++;
        if (pending_resps.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending",
                                    results_seen));
        end else begin
          want = pending_resps.pop_front();
          if (m_axis_tuser_o !== want.hit)
            report_mismatch($sformatf("result %0d: hit %b, want %b",
                                      results_seen, m_axis_tuser_o, want.hit));
          if (m_axis_tdata_o !== want.data)
            report_mismatch($sformatf("result %0d: data %h, want %h",
                                      results_seen, m_axis_tdata_o, want.data));
        end
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) ||
          (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("[%0t] no word moved for %0d cycles", $time, STALL_LIMIT);
          $display("fifo_replacement_assoc_cache_unit: mismatch");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed table. Rows start at slot count 16 with an empty cache; four
  // keys are placed, so the pointer sits at 4 when the count drops to 2.
  // --------------------------------------------------------------------------
  stim_row_t dir_rows [NUM_DIR_ROWS] = '{
    // empty cache: both key extremes miss, payload on a lookup is ignored
    '{ROW_FIXED,   FUNC_LOOKUP,   10'd0,   32'h0000_0000, 1'b0, 32'h0, 5'd0},
    '{ROW_FIXED,   FUNC_LOOKUP,   KEY_MAX, PAY_MAX,       1'b0, 32'h0, 5'd0},
    // fill with the extremes of key and payload
    '{ROW_FIXED,   FUNC_REGISTER, 10'd0,   32'h0000_0000, 1'b0, 32'h0, 5'd0},
    '{ROW_FIXED,   FUNC_REGISTER, KEY_MAX, PAY_MAX,       1'b0, 32'h0, 5'd0},
    '{ROW_FIXED,   FUNC_LOOKUP,   KEY_MAX, 32'h0000_0000, 1'b1, PAY_MAX, 5'd0},
    '{ROW_FIXED,   FUNC_LOOKUP,   10'd0,   32'h0000_0000, 1'b1, 32'h0, 5'd0},
    // duplicate register: hit, zero data, stored payload unchanged
    '{ROW_FIXED,   FUNC_REGISTER, KEY_MAX, 32'h1234_5678, 1'b1, 32'h0, 5'd0},
    '{ROW_FIXED,   FUNC_LOOKUP,   KEY_MAX, 32'h0000_0000, 1'b1, PAY_MAX, 5'd0},
    // alternating bit patterns
    '{ROW_PREDICT, FUNC_REGISTER, 10'h2AA, 32'hAAAA_AAAA, 1'b0, 32'h0, 5'd0},
    '{ROW_PREDICT, FUNC_REGISTER, 10'h155, 32'h5555_5555, 1'b0, 32'h0, 5'd0},
    '{ROW_PREDICT, FUNC_LOOKUP,   10'h2AA, 32'h0000_0000, 1'b0, 32'h0, 5'd0},
    '{ROW_PREDICT, FUNC_LOOKUP,   10'h155, 32'h0000_0000, 1'b0, 32'h0, 5'd0},
    // shrink below the pointer: next fill goes to slot 0
    '{ROW_CFG,     FUNC_LOOKUP,   10'd0,   32'h0000_0000, 1'b0, 32'h0, 5'd2},
    '{ROW_PREDICT, FUNC_REGISTER, 10'd7,   32'h0000_0007, 1'b0, 32'h0, 5'd0},
    '{ROW_PREDICT, FUNC_LOOKUP,   10'd0,   32'h0000_0000, 1'b0, 32'h0, 5'd0},
    // slot beyond the count is not searched
    '{ROW_PREDICT, FUNC_LOOKUP,   10'h2AA, 32'h0000_0000, 1'b0, 32'h0, 5'd0},
    '{ROW_PREDICT, FUNC_REGISTER, 10'd8,   32'h0000_0008, 1'b0, 32'h0, 5'd0},
    '{ROW_PREDICT, FUNC_REGISTER, 10'd9,   32'h0000_0009, 1'b0, 32'h0, 5'd0},
    '{ROW_PREDICT, FUNC_LOOKUP,   10'd7,   32'h0000_0000, 1'b0, 32'h0, 5'd0},
    // count of zero acts as one
    '{ROW_CFG,     FUNC_LOOKUP,   10'd0,   32'h0000_0000, 1'b0, 32'h0, 5'd0},
    '{ROW_PREDICT, FUNC_REGISTER, 10'd10,  32'hDEAD_BEEF, 1'b0, 32'h0, 5'd0},
    '{ROW_PREDICT, FUNC_LOOKUP,   10'd10,  32'h0000_0000, 1'b0, 32'h0, 5'd0},
    '{ROW_PREDICT, FUNC_LOOKUP,   10'd8,   32'h0000_0000, 1'b0, 32'h0, 5'd0},
    // count above depth acts as depth; parked slots come back into view
    '{ROW_CFG,     FUNC_LOOKUP,   10'd0,   32'h0000_0000, 1'b0, 32'h0, 5'd31},
    '{ROW_PREDICT, FUNC_LOOKUP,   10'h2AA, 32'h0000_0000, 1'b0, 32'h0, 5'd0},
    '{ROW_PREDICT, FUNC_LOOKUP,   10'd8,   32'h0000_0000, 1'b0, 32'h0, 5'd0}
  };

  // Slot counts for the random phases: reset value, extremes, just above
  // depth, and a few in between.
  logic [CFG_W-1:0] phase_counts [NUM_PHASES] = '{
    5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd3, 5'd8, 5'd16, 5'd5, 5'd12, 5'd2, 5'd16
  };

  initial begin
    int               eff;
    int               pool_base;
    int               pool_size;
    int               r;
    farc_func_e       func;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling.
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG: write_slot_count(dir_rows[i].slots);
        ROW_FIXED: begin
          send_word(dir_rows[i].func, dir_rows[i].key, dir_rows[i].payload, 1'b1,
                    '{hit: dir_rows[i].exp_hit, data: dir_rows[i].exp_data});
        end
        default: begin
          send_word(dir_rows[i].func, dir_rows[i].key, dir_rows[i].payload, 1'b0,
                    '0);
        end
      endcase
    end

    // Random phases: each picks a slot count and an idle/stall mix. Keys come
    // mostly from a pool a little larger than the active count, so lookups
    // hit, registers repeat keys, and the pointer wraps and evicts often.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_slot_count(phase_counts[ph]);
      case (ph % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      eff = (phase_counts[ph] == 0) ? 1 :
            (int'(phase_counts[ph]) > DEPTH) ? DEPTH : int'(phase_counts[ph]);
      pool_size = eff + 4;
      pool_base = $urandom_range(1023 - DEPTH - 4, 0);

      for (int w = 0; w < WORDS_PER_PHASE; w++) begin
        // Hold the receiver off for a long stretch and keep offering words,
        // so the unit fills up and stalls its input; then pause the sender
        // until every result is back.
        if (ph == PRESSURE_PHASE && w == WORDS_PER_PHASE / 2)
          holdoff_req = HOLDOFF_CYCLES;
        if (ph == PRESSURE_PHASE && w == WORDS_PER_PHASE / 2 + PRESSURE_WORDS)
          drain_results();

        func = ($urandom_range(99) < 45) ? FUNC_REGISTER : FUNC_LOOKUP;
        r = $urandom_range(99);
        if (r < 75)      key = KEY_W'(pool_base + $urandom_range(pool_size - 1, 0));
        else if (r < 90) key = KEY_W'($urandom_range(1023, 0));
        else             key = $urandom_range(1, 0) ? KEY_MAX : '0;
        r = $urandom_range(99);
        if (r < 85)      payload = $urandom;
        else if (r < 92) payload = '0;
        else             payload = PAY_MAX;
        send_word(func, key, payload, 1'b0, '0);
      end
    end

    // Let the last results drain, then leave a short margin.
    drain_results();
    repeat (4) @(posedge clk_i);

    $display("Covered %0d words: %0d lookups (%0d hits), %0d registers (%0d duplicates)",
             n_words, n_lookups, n_hits, n_registers, n_dups);
    $display("over %0d slot-count writes, four idle/stall mixes and a long output hold-off",
             cfg_writes);
    if (mismatch_count == 0) begin
      $display("fifo_replacement_assoc_cache_unit: match");
    end else begin
      $display("fifo_replacement_assoc_cache_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/farc_pkg.sv
rtl/farc_ram.sv
rtl/farc_tags.sv
rtl/fifo_replacement_assoc_cache_unit.sv
tb/sv/tb_fifo_replacement_assoc_cache_unit.sv
